// ===== rtl/core/lcd_spi_word_formatter_core_defines.svh =====
// ----------------------------------------------------------------------------
// LCD serial word formatter assertion macros
// Shared property forms for the concurrent checks of the formatter core.
// ----------------------------------------------------------------------------
`ifndef LCD_SPI_WORD_FORMATTER_CORE_DEFINES_SVH
`define LCD_SPI_WORD_FORMATTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define LCDSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define LCDSF_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lcdsf_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD serial word formatter package
// Types, register codes, reset values and colour packing shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdsf_pkg;

   // Input operation codes.
   localparam logic [2:0] MODE_RAW_CMD  = 3'd0;
   localparam logic [2:0] MODE_RAW_DATA = 3'd1;
   localparam logic [2:0] MODE_WINDOW   = 3'd2;
   localparam logic [2:0] MODE_PIXEL    = 3'd3;
   localparam logic [2:0] MODE_GLYPH    = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CONTROLLER_TYPE   = 3'd0;
   localparam logic [2:0] CSR_COLOR_DEPTH       = 3'd1;
   localparam logic [2:0] CSR_COLUMN_OPCODE     = 3'd2;
   localparam logic [2:0] CSR_PAGE_OPCODE       = 3'd3;
   localparam logic [2:0] CSR_WRITE_OPCODE      = 3'd4;
   localparam logic [2:0] CSR_ALT_COLUMN_OPCODE = 3'd5;
   localparam logic [2:0] CSR_ALT_PAGE_OPCODE   = 3'd6;
   localparam logic [2:0] CSR_ALT_WRITE_OPCODE  = 3'd7;

   // Field values of the configuration registers.
   localparam logic CTRL_TYPE_A = 1'b0;
   localparam logic DEPTH_8BIT  = 1'b0;

   // Register reset values.
   localparam logic [7:0] RST_COLUMN_OPCODE     = 8'd21;
   localparam logic [7:0] RST_PAGE_OPCODE       = 8'd117;
   localparam logic [7:0] RST_WRITE_OPCODE      = 8'd92;
   localparam logic [7:0] RST_ALT_COLUMN_OPCODE = 8'd42;
   localparam logic [7:0] RST_ALT_PAGE_OPCODE   = 8'd43;
   localparam logic [7:0] RST_ALT_WRITE_OPCODE  = 8'd44;

   // Bit 8 of a serial word marks data.
   localparam logic WORD_CMD  = 1'b0;
   localparam logic WORD_DATA = 1'b1;

   // Number of words in the address window sequence.
   localparam int unsigned WIN_WORDS = 7;
   localparam logic [2:0] WIN_LAST_IDX = 3'(WIN_WORDS - 1);

   // Glyph columns are eight pixels tall.
   localparam logic [2:0] GLYPH_LAST_PIX = 3'd7;
   localparam logic [7:0] GLYPH_HEIGHT   = 8'd8;

   // Channel scaling 0..15 to 0..7, rounding down.
   localparam logic [2:0] SCALE7_LUT [16] = '{
      3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3,
      3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7
   };

   typedef struct packed {
      logic       controller_type;
      logic       color_depth;
      logic [7:0] column_opcode;
      logic [7:0] page_opcode;
      logic [7:0] write_opcode;
      logic [7:0] alt_column_opcode;
      logic [7:0] alt_page_opcode;
      logic [7:0] alt_write_opcode;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_WINDOW,
      KIND_PIXEL,
      KIND_GLYPH
   } item_kind_type;

   typedef logic [2:0][7:0] color_bytes_type;

   // One classified operation as handed from the front to the back.
   typedef struct packed {
      item_kind_type          kind;
      logic [8:0]             single_word;
      logic [6:0][8:0]        win_word;
      color_bytes_type        fore_bytes;
      color_bytes_type        back_bytes;
      logic [1:0]             color_last;
      logic [7:0]             glyph_bits;
   } item_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SINGLE,
      SEQ_WINDOW,
      SEQ_COLOR
   } seq_state_type;

   // Command byte with the type B opcode substitution applied.
   function automatic logic [7:0] translate_cmd(input logic [7:0] cmd, input cfg_type cfg);
      logic [7:0] res;
      res = cmd;
      if (cfg.controller_type != CTRL_TYPE_A) begin
         if (cmd == cfg.column_opcode) begin
            res = cfg.alt_column_opcode;
         end else if (cmd == cfg.page_opcode) begin
            res = cfg.alt_page_opcode;
         end else if (cmd == cfg.write_opcode) begin
            res = cfg.alt_write_opcode;
         end
      end
      return res;
   endfunction

   // Channel scaling 0..15 to 0..3, rounding down.
   function automatic logic [1:0] scale3(input logic [3:0] n);
      logic [1:0] res;
      if (n == 4'd15) begin
         res = 2'd3;
      end else if (n >= 4'd10) begin
         res = 2'd2;
      end else if (n >= 4'd5) begin
         res = 2'd1;
      end else begin
         res = 2'd0;
      end
      return res;
   endfunction

   // Packed colour bytes, first byte in element 0.
   function automatic color_bytes_type pack_color(input logic [11:0] c, input cfg_type cfg);
      color_bytes_type res;
      res = '0;
      if (cfg.color_depth == DEPTH_8BIT) begin
         res[0] = {SCALE7_LUT[c[11:8]], SCALE7_LUT[c[7:4]], scale3(c[3:0])};
      end else if (cfg.controller_type == CTRL_TYPE_A) begin
         res[0] = c[11:4];
         res[1] = {c[3:0], c[11:8]};
         res[2] = c[7:0];
      end else begin
         res[0] = c[11:4];
         res[1] = {c[3:0], 4'h0};
      end
      return res;
   endfunction

   // Index of the final byte of one packed colour.
   function automatic logic [1:0] color_last_idx(input cfg_type cfg);
      logic [1:0] res;
      if (cfg.color_depth == DEPTH_8BIT) begin
         res = 2'd0;
      end else if (cfg.controller_type == CTRL_TYPE_A) begin
         res = 2'd2;
      end else begin
         res = 2'd1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lcd_spi_word_formatter_core.sv =====
// On an idle core the first word of an operation passes through the queue entry, the
// working descriptor and the output register.
// Throughput: one word per cycle while the receiver does not stall; an operation holds
// the word sequencer for all its words, from 1 (raw byte) to 31 (glyph column, 12-bit
// colour, type A controller). The operation queue takes new operations while the sequencer is busy.
// Reset clears the queue, the sequencer and the output valid flag, and returns the
// configuration registers to their reset values.
// ----------------------------------------------------------------------------
// LCD serial word formatter core
// Turns display operations into 9-bit serial command and data words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lcd_spi_word_formatter_core_defines.svh"

module lcd_spi_word_formatter_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [7:0]  req_x_start,
   input  wire logic [7:0]  req_y_start,
   input  wire logic [7:0]  req_x_end,
   input  wire logic [7:0]  req_y_end,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [11:0] req_fore_color,
   input  wire logic [11:0] req_back_color,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [8:0]       rsp_spi_word,
   output logic             rsp_last_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import lcdsf_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   item_desc_type    push_desc;
   item_desc_type    head_desc;
   logic             q_push;
   logic             q_pop;

   // Configuration registers; every write transaction is taken at once.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CONTROLLER_TYPE:   cfg_in.controller_type = csr_wdata[0];
            CSR_COLOR_DEPTH:       cfg_in.color_depth = csr_wdata[0];
            CSR_COLUMN_OPCODE:     cfg_in.column_opcode = csr_wdata;
            CSR_PAGE_OPCODE:       cfg_in.page_opcode = csr_wdata;
            CSR_WRITE_OPCODE:      cfg_in.write_opcode = csr_wdata;
            CSR_ALT_COLUMN_OPCODE: cfg_in.alt_column_opcode = csr_wdata;
            CSR_ALT_PAGE_OPCODE:   cfg_in.alt_page_opcode = csr_wdata;
            CSR_ALT_WRITE_OPCODE:  cfg_in.alt_write_opcode = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.controller_type <= CTRL_TYPE_A;
         cfg_ff.color_depth <= DEPTH_8BIT;
         cfg_ff.column_opcode <= RST_COLUMN_OPCODE;
         cfg_ff.page_opcode <= RST_PAGE_OPCODE;
         cfg_ff.write_opcode <= RST_WRITE_OPCODE;
         cfg_ff.alt_column_opcode <= RST_ALT_COLUMN_OPCODE;
         cfg_ff.alt_page_opcode <= RST_ALT_PAGE_OPCODE;
         cfg_ff.alt_write_opcode <= RST_ALT_WRITE_OPCODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts and classifies operations.
   lcdsf_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_byte_value (req_byte_value),
      .req_fore_color (req_fore_color),
      .req_back_color (req_back_color),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_desc         (push_desc)
   );

   // Operation queue between the two halves.
   lcdsf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .status    (q_status)
   );

   // Back end: word sequencer and output register.
   lcdsf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (head_desc),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_spi_word  (rsp_spi_word),
      .rsp_last_word (rsp_last_word)
   );

   // Queue and output consistency checks.
   `LCDSF_ASSERT_SAME(a_no_push_full, clock, reset, q_push, !q_status.full, "push into full queue")
   `LCDSF_ASSERT_SAME(a_no_pop_empty, clock, reset, q_pop, !q_status.empty, "pop from empty queue")
   `LCDSF_ASSERT_SAME(a_status_sane, clock, reset, q_status.full, !q_status.empty, "queue full and empty")
   `LCDSF_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid, "output valid after reset")

endmodule

`default_nettype wire

// ===== rtl/core/lcdsf_front.sv =====
// ----------------------------------------------------------------------------
// LCD serial word formatter front end
// Accepts operations, classifies them and prepares all words they need.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdsf_front (
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [2:0]                req_mode,
   input  wire logic [7:0]                req_x_start,
   input  wire logic [7:0]                req_y_start,
   input  wire logic [7:0]                req_x_end,
   input  wire logic [7:0]                req_y_end,
   input  wire logic [7:0]                req_byte_value,
   input  wire logic [11:0]               req_fore_color,
   input  wire logic [11:0]               req_back_color,
   input  wire lcdsf_pkg::cfg_type          cfg,
   input  wire lcdsf_pkg::queue_status_type q_status,
   output logic                           q_push,
   output lcdsf_pkg::item_desc_type         q_desc
);
   import lcdsf_pkg::*;

   logic       mode_known;
   logic [7:0] x2;
   logic [7:0] y2;

   // The front only waits for room in the queue.
   assign req_stall = q_status.full;

   // Classify the operation and build its descriptor.
   always_comb begin
      mode_known = 1'b1;
      x2 = req_x_end;
      y2 = req_y_end;
      q_desc = '0;
      q_desc.kind = KIND_SINGLE;
      case (req_mode)
         MODE_RAW_CMD: begin
            q_desc.kind = KIND_SINGLE;
            q_desc.single_word = {WORD_CMD, translate_cmd(req_byte_value, cfg)};
         end
         MODE_RAW_DATA: begin
            q_desc.kind = KIND_SINGLE;
            q_desc.single_word = {WORD_DATA, req_byte_value};
         end
         MODE_WINDOW: begin
            q_desc.kind = KIND_WINDOW;
         end
         MODE_PIXEL: begin
            q_desc.kind = KIND_PIXEL;
         end
         MODE_GLYPH: begin
            q_desc.kind = KIND_GLYPH;
            x2 = req_x_start;
            y2 = req_y_start + GLYPH_HEIGHT;
         end
         default: begin
            mode_known = 1'b0;
         end
      endcase

      // Address window: column, page, then memory write.
      q_desc.win_word[0] = {WORD_CMD, translate_cmd(cfg.column_opcode, cfg)};
      q_desc.win_word[1] = {WORD_DATA, req_x_start};
      q_desc.win_word[2] = {WORD_DATA, x2};
      q_desc.win_word[3] = {WORD_CMD, translate_cmd(cfg.page_opcode, cfg)};
      q_desc.win_word[4] = {WORD_DATA, req_y_start};
      q_desc.win_word[5] = {WORD_DATA, y2};
      q_desc.win_word[6] = {WORD_CMD, translate_cmd(cfg.write_opcode, cfg)};

      q_desc.fore_bytes = pack_color(req_fore_color, cfg);
      q_desc.back_bytes = pack_color(req_back_color, cfg);
      q_desc.color_last = color_last_idx(cfg);
      q_desc.glyph_bits = req_byte_value;
   end

   // Unused modes are taken and dropped without a queue entry.
   assign q_push = req_valid && !req_stall && mode_known;

endmodule

`default_nettype wire

// ===== rtl/core/lcdsf_queue.sv =====
// ----------------------------------------------------------------------------
// LCD serial word formatter operation queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdsf_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire lcdsf_pkg::item_desc_type     push_desc,
   input  wire logic                       pop,
   output lcdsf_pkg::item_desc_type          head_desc,
   output lcdsf_pkg::queue_status_type       status
);
   import lcdsf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_desc_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   assign head_desc = entry_ff[rd_ptr_ff];
   assign status.full = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/lcdsf_back.sv =====
// ----------------------------------------------------------------------------
// LCD serial word formatter back end
// Steps through each queued operation and emits one serial word per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdsf_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lcdsf_pkg::queue_status_type   q_status,
   input  wire lcdsf_pkg::item_desc_type      q_head,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [8:0]                       rsp_spi_word,
   output logic                             rsp_last_word
);
   import lcdsf_pkg::*;

   seq_state_type   state_ff, state_in;
   item_desc_type   desc_ff;
   logic [2:0]      win_idx_ff, win_idx_in;
   logic [2:0]      pix_idx_ff, pix_idx_in;
   logic [1:0]      byte_idx_ff, byte_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [8:0]      rsp_word_ff;
   logic            rsp_last_ff;

   logic            advance;
   logic            load;
   logic            last_byte;
   logic [8:0]      cur_word;
   logic            cur_last;
   color_bytes_type cur_color;

   // Current word, its end flag and the handshake with the queue.
   always_comb begin
      advance = (state_ff != SEQ_IDLE) && (!rsp_valid_ff || !rsp_stall);
      last_byte = (byte_idx_ff == desc_ff.color_last);
      if (desc_ff.kind == KIND_GLYPH && !desc_ff.glyph_bits[pix_idx_ff]) begin
         cur_color = desc_ff.back_bytes;
      end else begin
         cur_color = desc_ff.fore_bytes;
      end
      cur_word = desc_ff.single_word;
      cur_last = 1'b1;
      case (state_ff)
         SEQ_SINGLE: begin
            cur_word = desc_ff.single_word;
            cur_last = 1'b1;
         end
         SEQ_WINDOW: begin
            cur_word = desc_ff.win_word[win_idx_ff];
            cur_last = (win_idx_ff == WIN_LAST_IDX) && (desc_ff.kind != KIND_GLYPH);
         end
         SEQ_COLOR: begin
            cur_word = {WORD_DATA, cur_color[byte_idx_ff]};
            cur_last = last_byte
               && ((desc_ff.kind == KIND_PIXEL) || (pix_idx_ff == GLYPH_LAST_PIX));
         end
         default: begin
            cur_word = desc_ff.single_word;
            cur_last = 1'b0;
         end
      endcase
      load = !q_status.empty && ((state_ff == SEQ_IDLE) || (advance && cur_last));
   end

   assign q_pop = load;

   // Sequencer next state and position counters.
   always_comb begin
      state_in = state_ff;
      win_idx_in = win_idx_ff;
      pix_idx_in = pix_idx_ff;
      byte_idx_in = byte_idx_ff;
      if (load) begin
         win_idx_in = '0;
         pix_idx_in = '0;
         byte_idx_in = '0;
         case (q_head.kind)
            KIND_SINGLE: state_in = SEQ_SINGLE;
            KIND_WINDOW: state_in = SEQ_WINDOW;
            KIND_GLYPH:  state_in = SEQ_WINDOW;
            KIND_PIXEL:  state_in = SEQ_COLOR;
            default:     state_in = SEQ_IDLE;
         endcase
      end else if (advance) begin
         case (state_ff)
            SEQ_SINGLE: begin
               state_in = SEQ_IDLE;
            end
            SEQ_WINDOW: begin
               if (win_idx_ff == WIN_LAST_IDX) begin
                  state_in = (desc_ff.kind == KIND_GLYPH) ? SEQ_COLOR : SEQ_IDLE;
                  pix_idx_in = '0;
                  byte_idx_in = '0;
               end else begin
                  win_idx_in = win_idx_ff + 1'b1;
               end
            end
            SEQ_COLOR: begin
               if (last_byte) begin
                  byte_idx_in = '0;
                  if (cur_last) begin
                     state_in = SEQ_IDLE;
                  end else begin
                     pix_idx_in = pix_idx_ff + 1'b1;
                  end
               end else begin
                  byte_idx_in = byte_idx_ff + 1'b1;
               end
            end
            default: begin
               state_in = SEQ_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         win_idx_ff <= '0;
         pix_idx_ff <= '0;
         byte_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         win_idx_ff <= win_idx_in;
         pix_idx_ff <= pix_idx_in;
         byte_idx_ff <= byte_idx_in;
      end
   end

   // Working descriptor of the operation in progress.
   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= q_head;
      end
   end

   // Output register: holds a word until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= cur_word;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_spi_word = rsp_word_ff;
   assign rsp_last_word = rsp_last_ff;

endmodule

`default_nettype wire
